[src/mflc_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helpers for the multi-floor lift controller.
// No dependencies; every other file of the block imports this package.
package mflc_pkg;

   localparam int MAX_STATIONS = 16;
   localparam int STN_W        = 4;   // station number
   localparam int CNT_W        = 5;   // station count register
   localparam int DELAY_W      = 24;  // move / dwell delay registers
   localparam int ELAPSED_W    = 16;  // elapsed time of one tick
   localparam int TIMER_W      = 26;  // signed travel / dwell timers
   localparam int CSR_IDX_W    = 2;

   localparam logic [CNT_W-1:0]   STATION_COUNT_RST = CNT_W'(16);
   localparam logic [DELAY_W-1:0] MOVE_DELAY_RST    = DELAY_W'(1000);
   localparam logic [DELAY_W-1:0] DWELL_DELAY_RST   = DELAY_W'(2000);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STATION_COUNT = 2'd0,
      CSR_MOVE_DELAY    = 2'd1,
      CSR_DWELL_DELAY   = 2'd2
   } csr_index_type;

   typedef enum logic {
      MODE_TICK = 1'b0,
      MODE_CALL = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      DOOR_NONE  = 2'd0,
      DOOR_CLOSE = 2'd1,
      DOOR_OPEN  = 2'd2
   } door_cmd_type;

   typedef enum logic [1:0] {
      LIGHT_NONE = 2'd0,
      LIGHT_OFF  = 2'd1,
      LIGHT_ON   = 2'd2
   } light_cmd_type;

   typedef enum logic [2:0] {
      PH_WAITING = 3'd0,
      PH_CLOSING = 3'd1,
      PH_MOVING  = 3'd2,
      PH_OPENING = 3'd3,
      PH_DWELL   = 3'd4
   } phase_type;

   typedef struct packed {
      logic [CNT_W-1:0]   station_count;
      logic [DELAY_W-1:0] move_delay;
      logic [DELAY_W-1:0] dwell_delay;
   } cfg_type;

   typedef struct packed {
      logic                 mode;
      logic [STN_W-1:0]     call_station;
      logic [ELAPSED_W-1:0] elapsed_time;
      logic                 door_is_open;
   } req_type;

   typedef struct packed {
      door_cmd_type     door_command;
      light_cmd_type    light_command;
      phase_type        lift_state;
      logic [STN_W-1:0] current_station;
      logic             moving_up;
      logic             arrived;
   } rsp_type;

   typedef struct packed {
      logic [MAX_STATIONS-1:0]   call_bits;
      logic [STN_W-1:0]          position;
      logic [STN_W-1:0]          target;
      logic                      target_valid;
      logic                      heading_up;
      phase_type                 phase;
      logic signed [TIMER_W-1:0] travel_timer;
      logic signed [TIMER_W-1:0] dwell_timer;
   } lift_state_type;

   // nearest calls around the current station
   typedef struct packed {
      logic             upper_found;
      logic [STN_W-1:0] upper;
      logic             lower_found;
      logic [STN_W-1:0] lower;
   } search_type;

   // saturate a one-bit-wider timer result back to timer range
   function automatic logic signed [TIMER_W-1:0] sat_timer(input logic signed [TIMER_W:0] v);
      logic signed [TIMER_W-1:0] r;
      r = v[TIMER_W-1:0];
      if (v[TIMER_W] != v[TIMER_W-1]) begin
         r = v[TIMER_W] ? {1'b1, {(TIMER_W-1){1'b0}}} : {1'b0, {(TIMER_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

[src/mflc_if.sv]
`timescale 1ns / 1ps
// Handshake channels of the lift controller: request, response and CSR write.
// Depends on mflc_pkg for field widths.
interface mflc_req_if import mflc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [STN_W-1:0]     call_station;
   logic [ELAPSED_W-1:0] elapsed_time;
   logic                 door_is_open;
   modport source (output valid, mode, call_station, elapsed_time, door_is_open, input ready);
   modport sink   (input valid, mode, call_station, elapsed_time, door_is_open, output ready);
endinterface

interface mflc_rsp_if import mflc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       door_command;
   logic [1:0]       light_command;
   logic [2:0]       lift_state;
   logic [STN_W-1:0] current_station;
   logic             moving_up;
   logic             arrived;
   modport source (output valid, door_command, light_command, lift_state, current_station,
                   moving_up, arrived, input ready);
   modport sink   (input valid, door_command, light_command, lift_state, current_station,
                   moving_up, arrived, output ready);
endinterface

interface mflc_csr_if import mflc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DELAY_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[src/mflc_search.sv]
`timescale 1ns / 1ps
// Priority encoders that find the nearest pending call at or above (lower
// numbers) and at or below (higher numbers) the current station. Uses mflc_pkg.
module mflc_search import mflc_pkg::*; (
   input  logic [MAX_STATIONS-1:0] call_bits,
   input  logic [STN_W-1:0]        position,
   input  logic [CNT_W-1:0]        station_count,
   output search_type              srch
);

   logic [CNT_W-1:0]        used;
   logic [MAX_STATIONS-1:0] upper_mask;
   logic [MAX_STATIONS-1:0] lower_mask;

   assign used = (station_count > CNT_W'(MAX_STATIONS)) ? CNT_W'(MAX_STATIONS) : station_count;

   always_comb begin
      for (int i = 0; i < MAX_STATIONS; i++) begin
         // upward search has no station-count limit, downward search does
         upper_mask[i] = call_bits[i] && (STN_W'(i) <= position);
         lower_mask[i] = call_bits[i] && (STN_W'(i) >= position) && (CNT_W'(i) < used);
      end
   end

   always_comb begin
      srch = '0;
      for (int i = 0; i < MAX_STATIONS; i++) begin
         if (upper_mask[i]) begin
            srch.upper_found = 1'b1;
            srch.upper       = STN_W'(i);
         end
      end
      for (int i = MAX_STATIONS - 1; i >= 0; i--) begin
         if (lower_mask[i]) begin
            srch.lower_found = 1'b1;
            srch.lower       = STN_W'(i);
         end
      end
   end

endmodule

[src/mflc_step.sv]
`timescale 1ns / 1ps
// Next-state and response logic for one request of the lift controller.
// Uses mflc_pkg; takes the call search result from mflc_search.
module mflc_step import mflc_pkg::*; (
   input  lift_state_type state,
   input  cfg_type        cfg,
   input  req_type        req,
   input  search_type     srch,
   output lift_state_type state_in,
   output rsp_type        rsp
);

   logic [CNT_W-1:0]            used;
   logic signed [TIMER_W:0]     travel_diff;
   logic signed [TIMER_W-1:0]   travel_sat;
   logic signed [TIMER_W:0]     travel_sum;
   logic signed [TIMER_W:0]     dwell_diff;
   logic signed [TIMER_W-1:0]   dwell_sat;
   logic                        blocked;
   logic [STN_W-1:0]            next_pos;
   logic                        dest_found;
   logic [STN_W-1:0]            dest;
   logic                        dest_heading;

   assign used = (cfg.station_count > CNT_W'(MAX_STATIONS)) ?
                 CNT_W'(MAX_STATIONS) : cfg.station_count;

   assign travel_diff = (TIMER_W+1)'(state.travel_timer) - (TIMER_W+1)'(req.elapsed_time);
   assign travel_sat  = sat_timer(travel_diff);
   assign travel_sum  = (TIMER_W+1)'(travel_sat) + (TIMER_W+1)'(cfg.move_delay);
   assign dwell_diff  = (TIMER_W+1)'(state.dwell_timer) - (TIMER_W+1)'(req.elapsed_time);
   assign dwell_sat   = sat_timer(dwell_diff);

   // ends of the shaft stop the car regardless of station count
   assign blocked  = state.heading_up ? (state.position == '0)
                                      : (state.position == STN_W'(MAX_STATIONS - 1));
   assign next_pos = blocked ? state.position
                   : (state.heading_up ? state.position - 1'b1 : state.position + 1'b1);

   // keep going in the current direction, else turn around
   always_comb begin
      dest_heading = state.heading_up;
      if (!state.heading_up) begin
         if (srch.lower_found) begin
            dest_found = 1'b1;
            dest       = srch.lower;
         end else begin
            dest_found   = srch.upper_found;
            dest         = srch.upper;
            dest_heading = 1'b1;
         end
      end else begin
         if (srch.upper_found) begin
            dest_found = 1'b1;
            dest       = srch.upper;
         end else begin
            dest_found   = srch.lower_found;
            dest         = srch.lower;
            dest_heading = 1'b0;
         end
      end
   end

   always_comb begin
      state_in          = state;
      rsp.door_command  = DOOR_NONE;
      rsp.light_command = LIGHT_NONE;
      rsp.arrived       = 1'b0;

      if (req.mode == MODE_CALL) begin
         if (CNT_W'(req.call_station) < used) begin
            state_in.call_bits = state.call_bits | (MAX_STATIONS'(1) << req.call_station);
         end
      end else begin
         case (state.phase)
            PH_CLOSING: begin
               if (!req.door_is_open) begin
                  state_in.phase        = PH_MOVING;
                  state_in.travel_timer = TIMER_W'(cfg.move_delay);
                  rsp.light_command     = LIGHT_OFF;
               end
            end
            PH_MOVING: begin
               state_in.travel_timer = travel_sat;
               if (travel_sat < 0) begin
                  state_in.position = next_pos;
                  if (blocked || !state.target_valid || next_pos == state.target) begin
                     state_in.target_valid = 1'b0;
                     state_in.phase        = PH_OPENING;
                     state_in.call_bits    = state.call_bits & ~(MAX_STATIONS'(1) << next_pos);
                     rsp.door_command      = DOOR_OPEN;
                     rsp.arrived           = 1'b1;
                  end else begin
                     state_in.travel_timer = sat_timer(travel_sum);
                  end
               end
            end
            PH_OPENING: begin
               if (req.door_is_open) begin
                  state_in.phase       = PH_DWELL;
                  state_in.dwell_timer = TIMER_W'(cfg.dwell_delay);
               end
            end
            PH_DWELL: begin
               state_in.dwell_timer = dwell_sat;
               if (dwell_sat < 0) begin
                  state_in.phase        = PH_WAITING;
                  state_in.target_valid = 1'b0;
                  rsp.light_command     = LIGHT_ON;
               end
            end
            default: begin
               state_in.phase      = PH_WAITING;
               state_in.heading_up = dest_heading;
               if (dest_found && dest == state.position) begin
                  // call at own station: serve it in place
                  state_in.target_valid = 1'b0;
                  state_in.call_bits    = state.call_bits & ~(MAX_STATIONS'(1) << state.position);
               end else if (dest_found) begin
                  state_in.target       = dest;
                  state_in.target_valid = 1'b1;
                  state_in.phase        = PH_CLOSING;
                  rsp.door_command      = DOOR_CLOSE;
               end else begin
                  state_in.target_valid = 1'b0;
               end
            end
         endcase
      end

      rsp.lift_state      = state_in.phase;
      rsp.current_station = state_in.position;
      rsp.moving_up       = state_in.heading_up;
   end

endmodule

[src/multi_floor_lift_controller_core.sv]
`timescale 1ns / 1ps
// Multi-floor lift controller top level: CSR bank, request register, state
// and response register. Uses mflc_pkg, mflc_if, mflc_search and mflc_step.
//
// Usage:
//   req_chan  - one request per handshake: a call button press (mode 1) that
//               latches a call for call_station, or a time tick (mode 0) that
//               advances the controller by elapsed_time with the reported door.
//   rsp_chan  - exactly one response per request, in request order: door and
//               light commands, phase, station, direction and arrival flag.
//   csr_chan  - writes station_count (0), move_delay (1), dwell_delay (2);
//               always ready, index 3 is ignored. Write only while idle.
// Timing: an accepted request is held in the input register, and its response
//   is registered from it into the response register once that register is
//   free. One request per cycle is sustained while rsp_chan.ready stays high:
//   the whole step is a single pass through the call encoders and the timer
//   adders.
// Reset (synchronous): no calls, station 0, heading down, waiting, timers
//   zero, registers back to 16 / 1000 / 2000; both channels empty.
// Stall: while rsp_chan.ready is low the response holds, the input register
//   keeps one more request and req_chan.ready drops once both are full.
module multi_floor_lift_controller_core import mflc_pkg::*; (
   input logic         clock,
   input logic         reset,
   mflc_req_if.sink    req_chan,
   mflc_rsp_if.source  rsp_chan,
   mflc_csr_if.sink    csr_chan
);

   cfg_type        cfg_ff;
   lift_state_type state_ff;
   lift_state_type state_in;
   logic           in_valid_ff;
   req_type        in_data_ff;
   logic           rsp_valid_ff;
   rsp_type        rsp_data_ff;
   rsp_type        rsp_in;
   search_type     srch;
   logic           advance;
   logic           fire;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = in_valid_ff && advance;
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   mflc_search u_search (
      .call_bits     (state_ff.call_bits),
      .position      (state_ff.position),
      .station_count (cfg_ff.station_count),
      .srch          (srch)
   );

   mflc_step u_step (
      .state    (state_ff),
      .cfg      (cfg_ff),
      .req      (in_data_ff),
      .srch     (srch),
      .state_in (state_in),
      .rsp      (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         cfg_ff.station_count  <= STATION_COUNT_RST;
         cfg_ff.move_delay     <= MOVE_DELAY_RST;
         cfg_ff.dwell_delay    <= DWELL_DELAY_RST;
         state_ff.call_bits    <= '0;
         state_ff.position     <= '0;
         state_ff.target       <= '1;
         state_ff.target_valid <= 1'b0;
         state_ff.heading_up   <= 1'b0;
         state_ff.phase        <= PH_WAITING;
         state_ff.travel_timer <= '0;
         state_ff.dwell_timer  <= '0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (fire) begin
            state_ff <= state_in;
         end
         if (csr_chan.valid) begin
            case (csr_index_type'(csr_chan.index))
               CSR_STATION_COUNT: cfg_ff.station_count <= csr_chan.data[CNT_W-1:0];
               CSR_MOVE_DELAY:    cfg_ff.move_delay    <= csr_chan.data;
               CSR_DWELL_DELAY:   cfg_ff.dwell_delay   <= csr_chan.data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff.mode         <= req_chan.mode;
         in_data_ff.call_station <= req_chan.call_station;
         in_data_ff.elapsed_time <= req_chan.elapsed_time;
         in_data_ff.door_is_open <= req_chan.door_is_open;
      end
      if (fire) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.door_command    = rsp_data_ff.door_command;
   assign rsp_chan.light_command   = rsp_data_ff.light_command;
   assign rsp_chan.lift_state      = rsp_data_ff.lift_state;
   assign rsp_chan.current_station = rsp_data_ff.current_station;
   assign rsp_chan.moving_up       = rsp_data_ff.moving_up;
   assign rsp_chan.arrived         = rsp_data_ff.arrived;

endmodule

[src/mflc_checker.sv]
`timescale 1ns / 1ps
// Port-level assertions for the lift controller response channel, bound to
// multi_floor_lift_controller_core. Uses mflc_pkg for command and phase codes.
module mflc_checker import mflc_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] door_command,
   input logic [1:0] light_command,
   input logic [2:0] lift_state,
   input logic       arrived
);

   // stalled response must hold
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(lift_state) && $stable(arrived))
      else $error("response changed while stalled");

   // door open request only comes with arrival and the opening phase
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (door_command == DOOR_OPEN || arrived) |->
         door_command == DOOR_OPEN && arrived && lift_state == PH_OPENING)
      else $error("door open without arrival");

   // door close request only when departing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && door_command == DOOR_CLOSE |->
         lift_state == PH_CLOSING && light_command == LIGHT_NONE)
      else $error("door close outside departure");

   // lights go off when moving off, back on when returning to waiting
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && light_command != LIGHT_NONE |->
         (light_command == LIGHT_OFF && lift_state == PH_MOVING) ||
         (light_command == LIGHT_ON && lift_state == PH_WAITING))
      else $error("light command in wrong phase");

endmodule

bind multi_floor_lift_controller_core mflc_checker u_mflc_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .door_command  (rsp_chan.door_command),
   .light_command (rsp_chan.light_command),
   .lift_state    (rsp_chan.lift_state),
   .arrived       (rsp_chan.arrived)
);

[sim/tb_multi_floor_lift_controller_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for multi_floor_lift_controller_core: a directed table, then random
// calls and ticks over several register settings, checked against an in-bench lift model.
// Depends on mflc_pkg, the mflc_*_if interfaces and the core itself.
module tb_multi_floor_lift_controller_core;
   import mflc_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int N_DIRECTED     = 23;
   localparam int N_PHASES       = 8;
   localparam int ITEMS_PER_PHASE = 205;
   localparam longint TIMER_TOP  = 64'sd33554431;
   localparam longint TIMER_BOT  = -64'sd33554432;

   typedef struct packed {
      logic    is_cfg;
      cfg_type cfg;
      req_type req;
      logic    typed;   // golden below was written by hand
      rsp_type golden;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset;

   mflc_req_if req_chan ();
   mflc_rsp_if rsp_chan ();
   mflc_csr_if csr_chan ();

   multi_floor_lift_controller_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // lift model state and registers
   cfg_type          lift_cfg;
   logic [15:0]      lift_calls;
   logic [STN_W-1:0] lift_pos;
   logic [STN_W-1:0] lift_target;
   logic             lift_target_ok;
   logic             lift_up;
   phase_type        lift_phase;
   longint           move_left;
   longint           dwell_left;

   rsp_type      lift_reports_due[$];
   rsp_type      due;
   plan_row_type directed [N_DIRECTED];
   cfg_type      cfg_plan [N_PHASES];
   int           mismatches = 0;
   int           cycle_count = 0;
   logic         quiet = 1'b0;

   function automatic longint clamp_timer(input longint v);
      if (v > TIMER_TOP) return TIMER_TOP;
      if (v < TIMER_BOT) return TIMER_BOT;
      return v;
   endfunction

   function automatic int stations_in_use();
      return (lift_cfg.station_count < MAX_STATIONS) ? int'(lift_cfg.station_count) : MAX_STATIONS;
   endfunction

   // one accepted request through the lift model; returns the report it should produce
   function automatic rsp_type advance_lift(input req_type r);
      rsp_type o;
      int      n, upper, lower, dest, i;
      logic    blocked;
      o = '0;
      o.door_command  = DOOR_NONE;
      o.light_command = LIGHT_NONE;
      if (r.mode == MODE_CALL) begin
         if (int'(r.call_station) < stations_in_use()) lift_calls[r.call_station] = 1'b1;
      end else begin
         case (lift_phase)
            PH_CLOSING: begin
               if (!r.door_is_open) begin
                  lift_phase      = PH_MOVING;
                  move_left       = longint'(lift_cfg.move_delay);
                  o.light_command = LIGHT_OFF;
               end
            end
            PH_MOVING: begin
               move_left = clamp_timer(move_left - longint'(r.elapsed_time));
               if (move_left < 0) begin
                  blocked = lift_up ? (lift_pos == 0) : (lift_pos >= MAX_STATIONS - 1);
                  if (!blocked) lift_pos = lift_up ? lift_pos - 1'b1 : lift_pos + 1'b1;
                  if (blocked || !lift_target_ok || lift_pos == lift_target) begin
                     lift_target_ok       = 1'b0;
                     lift_phase           = PH_OPENING;
                     o.door_command       = DOOR_OPEN;
                     lift_calls[lift_pos] = 1'b0;
                     o.arrived            = 1'b1;
                  end else begin
                     move_left = clamp_timer(move_left + longint'(lift_cfg.move_delay));
                  end
               end
            end
            PH_OPENING: begin
               if (r.door_is_open) begin
                  lift_phase = PH_DWELL;
                  dwell_left = longint'(lift_cfg.dwell_delay);
               end
            end
            PH_DWELL: begin
               dwell_left = clamp_timer(dwell_left - longint'(r.elapsed_time));
               if (dwell_left < 0) begin
                  o.light_command = LIGHT_ON;
                  lift_phase      = PH_WAITING;
                  lift_target_ok  = 1'b0;
               end
            end
            default: begin
               lift_phase = PH_WAITING;
               n     = stations_in_use();
               upper = -1;
               lower = -1;
               // nearest call toward station 0, and nearest toward the bottom
               for (i = int'(lift_pos); i >= 0; i--)
                  if (upper < 0 && lift_calls[i]) upper = i;
               for (i = int'(lift_pos); i < n; i++)
                  if (lower < 0 && lift_calls[i]) lower = i;
               if (!lift_up) begin
                  if (lower >= 0) dest = lower;
                  else begin
                     dest    = upper;
                     lift_up = 1'b1;
                  end
               end else begin
                  if (upper >= 0) dest = upper;
                  else begin
                     dest    = lower;
                     lift_up = 1'b0;
                  end
               end
               if (dest == int'(lift_pos)) begin
                  lift_target_ok       = 1'b0;
                  lift_calls[lift_pos] = 1'b0;
               end else if (dest >= 0) begin
                  lift_target    = dest[STN_W-1:0];
                  lift_target_ok = 1'b1;
                  lift_phase     = PH_CLOSING;
                  o.door_command = DOOR_CLOSE;
               end else begin
                  lift_target_ok = 1'b0;
               end
            end
         endcase
      end
      o.lift_state      = lift_phase;
      o.current_station = lift_pos;
      o.moving_up       = lift_up;
      return o;
   endfunction

   function automatic rsp_type report(input door_cmd_type d, input light_cmd_type l,
                                      input phase_type ph, input int st, input int up,
                                      input int arr);
      rsp_type o;
      o.door_command    = d;
      o.light_command   = l;
      o.lift_state      = ph;
      o.current_station = st[STN_W-1:0];
      o.moving_up       = (up != 0);
      o.arrived         = (arr != 0);
      return o;
   endfunction

   function automatic plan_row_type tick_row(input int el, input int door, input int typed,
                                             input rsp_type g);
      plan_row_type row;
      row                  = '0;
      row.req.mode         = MODE_TICK;
      row.req.elapsed_time = el[ELAPSED_W-1:0];
      row.req.door_is_open = (door != 0);
      row.typed            = (typed != 0);
      row.golden           = g;
      return row;
   endfunction

   function automatic plan_row_type call_row(input int st, input int typed, input rsp_type g);
      plan_row_type row;
      row                  = '0;
      row.req.mode         = MODE_CALL;
      row.req.call_station = st[STN_W-1:0];
      row.typed            = (typed != 0);
      row.golden           = g;
      return row;
   endfunction

   function automatic plan_row_type cfg_row(input cfg_type c);
      plan_row_type row;
      row        = '0;
      row.is_cfg = 1'b1;
      row.cfg    = c;
      return row;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_request(input req_type r, output rsp_type predicted);
      if (!quiet) begin
         while ($urandom_range(99) < 7) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= r.mode;
      req_chan.call_station <= r.call_station;
      req_chan.elapsed_time <= r.elapsed_time;
      req_chan.door_is_open <= r.door_is_open;
      do @(posedge clock); while (!req_chan.ready);
      predicted = advance_lift(r);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [DELAY_W-1:0] d);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= d;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // drain the lift completely, then load all three registers
   task automatic write_settings(input cfg_type c);
      req_chan.valid <= 1'b0;
      while (lift_reports_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      write_register(CSR_STATION_COUNT, DELAY_W'(c.station_count));
      write_register(CSR_MOVE_DELAY, c.move_delay);
      write_register(CSR_DWELL_DELAY, c.dwell_delay);
      csr_chan.valid <= 1'b0;
      lift_cfg = c;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** multi_floor_lift_controller_core: FAILED **");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_chan.ready <= quiet || ($urandom_range(99) >= 7);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (lift_reports_due.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
         end else begin
            due = lift_reports_due.pop_front();
            check_field("door_command", int'(due.door_command), int'(rsp_chan.door_command));
            check_field("light_command", int'(due.light_command), int'(rsp_chan.light_command));
            check_field("lift_state", int'(due.lift_state), int'(rsp_chan.lift_state));
            check_field("current_station", int'(due.current_station),
                        int'(rsp_chan.current_station));
            check_field("moving_up", int'(due.moving_up), int'(rsp_chan.moving_up));
            check_field("arrived", int'(due.arrived), int'(rsp_chan.arrived));
         end
      end
   end

   initial begin
      req_type r;
      rsp_type predicted;
      int      k, p, sel, span;

      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.mode         <= MODE_TICK;
      req_chan.call_station <= '0;
      req_chan.elapsed_time <= '0;
      req_chan.door_is_open <= 1'b0;
      csr_chan.valid        <= 1'b0;
      csr_chan.index        <= CSR_STATION_COUNT;
      csr_chan.data         <= '0;

      lift_cfg       = '{STATION_COUNT_RST, MOVE_DELAY_RST, DWELL_DELAY_RST};
      lift_calls     = '0;
      lift_pos       = '0;
      lift_target    = '1;
      lift_target_ok = 1'b0;
      lift_up        = 1'b0;
      lift_phase     = PH_WAITING;
      move_left      = 0;
      dwell_left     = 0;

      directed = '{
         // no calls: direction flips each tick
         tick_row(0, 0, 1, report(DOOR_NONE, LIGHT_NONE, PH_WAITING, 0, 1, 0)),
         tick_row(0, 0, 1, report(DOOR_NONE, LIGHT_NONE, PH_WAITING, 0, 0, 0)),
         call_row(15, 0, '0),
         call_row(0, 0, '0),
         // call at own station is cleared without a door command
         tick_row(0, 0, 1, report(DOOR_NONE, LIGHT_NONE, PH_WAITING, 0, 0, 0)),
         call_row(2, 0, '0),
         tick_row(0, 0, 1, report(DOOR_CLOSE, LIGHT_NONE, PH_CLOSING, 0, 0, 0)),
         // door still open while closing
         tick_row(0, 1, 1, report(DOOR_NONE, LIGHT_NONE, PH_CLOSING, 0, 0, 0)),
         tick_row(0, 0, 1, report(DOOR_NONE, LIGHT_OFF, PH_MOVING, 0, 0, 0)),
         tick_row(1000, 0, 1, report(DOOR_NONE, LIGHT_NONE, PH_MOVING, 0, 0, 0)),
         tick_row(65535, 0, 1, report(DOOR_NONE, LIGHT_NONE, PH_MOVING, 1, 0, 0)),
         tick_row(0, 0, 1, report(DOOR_OPEN, LIGHT_NONE, PH_OPENING, 2, 0, 1)),
         tick_row(0, 0, 0, '0),
         tick_row(0, 1, 0, '0),
         tick_row(2000, 1, 0, '0),
         tick_row(1, 1, 1, report(DOOR_NONE, LIGHT_ON, PH_WAITING, 2, 0, 0)),
         tick_row(0, 0, 0, '0),
         cfg_row('{5'd2, 24'd0, 24'd0}),
         tick_row(0, 0, 1, report(DOOR_NONE, LIGHT_OFF, PH_MOVING, 2, 0, 0)),
         // call beyond the stations in use is dropped
         call_row(15, 1, report(DOOR_NONE, LIGHT_NONE, PH_MOVING, 2, 0, 0)),
         call_row(1, 0, '0),
         tick_row(0, 0, 1, report(DOOR_NONE, LIGHT_NONE, PH_MOVING, 2, 0, 0)),
         // zero move delay still passes only one station per tick
         tick_row(65535, 0, 1, report(DOOR_NONE, LIGHT_NONE, PH_MOVING, 3, 0, 0))
      };

      cfg_plan = '{
         '{5'd16, 24'd1000, 24'd2000},
         '{5'd2, 24'd0, 24'd0},
         '{5'd16, 24'd0, 24'd0},
         '{5'd5, 24'd300, 24'd100},
         '{5'd2, 24'hFFFFFF, 24'd5},
         '{5'd16, 24'd7, 24'd3},
         '{5'd3, 24'd50, 24'hFFFFFF},
         '{5'd16, 24'd1000, 24'd2000}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < N_DIRECTED; k++) begin
         if (directed[k].is_cfg) begin
            write_settings(directed[k].cfg);
         end else begin
            send_request(directed[k].req, predicted);
            lift_reports_due.push_back(directed[k].typed ? directed[k].golden : predicted);
         end
      end

      for (p = 0; p < N_PHASES; p++) begin
         write_settings(cfg_plan[p]);
         quiet = (p == 2);
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            r.mode         = MODE_TICK;
            r.call_station = STN_W'($urandom_range(15));
            r.elapsed_time = ELAPSED_W'($urandom);
            r.door_is_open = 1'($urandom_range(1));
            if ($urandom_range(99) < 20) begin
               r.mode = MODE_CALL;
            end else begin
               span = (lift_phase == PH_DWELL) ? int'(lift_cfg.dwell_delay)
                                               : int'(lift_cfg.move_delay);
               span = (span * 2 + 1 > 65535) ? 65535 : span * 2 + 1;
               sel  = $urandom_range(99);
               if (sel < 8) r.elapsed_time = '0;
               else if (sel < 13) r.elapsed_time = '1;
               else if (sel < 70) r.elapsed_time = ELAPSED_W'($urandom_range(span));
               // mostly report the door the way a real door would follow the commands
               case (lift_phase)
                  PH_CLOSING:          r.door_is_open = ($urandom_range(99) < 25);
                  PH_OPENING, PH_DWELL: r.door_is_open = ($urandom_range(99) < 75);
                  default:             r.door_is_open = 1'($urandom_range(1));
               endcase
            end
            send_request(r, predicted);
            lift_reports_due.push_back(predicted);
         end
      end

      req_chan.valid <= 1'b0;
      while (lift_reports_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && lift_reports_due.size() == 0) begin
         $display("** multi_floor_lift_controller_core: PASSED **");
      end else begin
         $display("** multi_floor_lift_controller_core: FAILED **");
      end
      $finish;
   end

endmodule

[files.f]
src/mflc_pkg.sv
src/mflc_if.sv
src/mflc_search.sv
src/mflc_step.sv
src/multi_floor_lift_controller_core.sv
src/mflc_checker.sv
sim/tb_multi_floor_lift_controller_core.sv
